// ----- hw/rtl/srtf_pkg.sv -----
package srtf_pkg;

   localparam int unsigned MaxSymbols = 32;
   localparam int unsigned DigitSlots = 32;
   localparam int unsigned QueueDepth = 2;

   localparam logic [7:0] SymMinus = 8'h2D;
   localparam logic [7:0] SymPlus  = 8'h2B;

   localparam logic [2:0] RegAlphaLo    = 3'd0;
   localparam logic [2:0] RegAlphaMidLo = 3'd1;
   localparam logic [2:0] RegAlphaMidHi = 3'd2;
   localparam logic [2:0] RegAlphaHi    = 3'd3;
   localparam logic [2:0] RegRadixLen   = 3'd4;

   typedef logic [31:0][7:0] alphabet_type;

   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
      logic [5:0]  len;
   } job_type;

endpackage

// ----- hw/rtl/srtf_queue.sv -----
module srtf_queue
   import srtf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type    slot_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'(QueueDepth));
   assign empty   = (count_ff == 2'd0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop && !empty) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hw/rtl/srtf_front.sv -----
module srtf_front
   import srtf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [31:0]  number_value,
   output logic         busy,
   input  alphabet_type alphabet,
   input  logic [5:0]   radix_len,
   output logic         push,
   output job_type      push_job,
   input  logic         full
);

   typedef enum logic [1:0] {F_IDLE, F_CHECK, F_PUSH} state_type;

   state_type  state_ff;
   job_type    job_ff;
   logic [4:0] idx_ff;
   logic [7:0] cur_sym;
   logic       bad;

   assign cur_sym  = alphabet[idx_ff];
   assign busy     = (state_ff != F_IDLE);
   assign push     = (state_ff == F_PUSH) && !full;
   assign push_job = job_ff;

   // symbol at idx is a sign or repeats later within the length
   always_comb begin
      bad = (cur_sym == SymMinus) || (cur_sym == SymPlus);
      for (int j = 0; j < 32; j++) begin
         if ((6'(j) > {1'b0, idx_ff}) && (6'(j) < job_ff.len) && (alphabet[j] == cur_sym)) begin
            bad = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         idx_ff   <= 5'd0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  job_ff.neg <= number_value[31];
                  job_ff.mag <= number_value[31] ? (32'd0 - number_value) : number_value;
                  job_ff.len <= radix_len;
                  idx_ff     <= 5'd0;
                  if (radix_len >= 6'd2 && {1'b0, radix_len} <= 7'(MaxSymbols)) begin
                     state_ff <= F_CHECK;
                  end
               end
            end
            F_CHECK: begin
               if (bad) begin
                  state_ff <= F_IDLE;
               end else if ({1'b0, idx_ff} == job_ff.len - 6'd1) begin
                  state_ff <= F_PUSH;
               end else begin
                  idx_ff <= idx_ff + 5'd1;
               end
            end
            F_PUSH: begin
               if (!full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/srtf_back.sv -----
module srtf_back
   import srtf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  alphabet_type alphabet,
   input  logic         empty,
   input  job_type      pop_job,
   output logic         pop,
   output logic         rsp_valid,
   output logic [7:0]   rsp_text_symbol,
   output logic         rsp_final_symbol
);

   typedef enum logic [1:0] {B_IDLE, B_DIV, B_SIGN, B_EMIT} state_type;

   state_type   state_ff;
   logic        neg_ff;
   logic [5:0]  len_ff;
   logic [31:0] mag_ff;
   logic [5:0]  rem_ff;
   logic [1:0]  step_ff;
   logic [5:0]  cnt_ff;
   logic [5:0]  k_ff;
   logic [4:0]  store_ff [DigitSlots];
   logic        valid_ff;
   logic [7:0]  sym_ff;
   logic        final_ff;

   logic [5:0]  rem_in;
   logic [7:0]  quo;
   logic [31:0] mag_in;

   assign pop              = (state_ff == B_IDLE) && !empty;
   assign rsp_valid        = valid_ff;
   assign rsp_text_symbol  = sym_ff;
   assign rsp_final_symbol = final_ff;

   // eight restoring division steps per cycle
   always_comb begin
      rem_in = rem_ff;
      quo    = 8'd0;
      for (int b = 0; b < 8; b++) begin
         rem_in = {rem_in[4:0], mag_ff[31 - b]};
         if (rem_in >= len_ff) begin
            rem_in      = rem_in - len_ff;
            quo[7 - b]  = 1'b1;
         end
      end
      mag_in = {mag_ff[23:0], quo};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= 6'd0;
         k_ff     <= 6'd0;
         step_ff  <= 2'd0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  neg_ff   <= pop_job.neg;
                  len_ff   <= pop_job.len;
                  mag_ff   <= pop_job.mag;
                  rem_ff   <= 6'd0;
                  step_ff  <= 2'd0;
                  cnt_ff   <= 6'd0;
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               mag_ff  <= mag_in;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  store_ff[cnt_ff[4:0]] <= rem_in[4:0];
                  cnt_ff <= cnt_ff + 6'd1;
                  rem_ff <= 6'd0;
                  if (mag_in == 32'd0 || cnt_ff == 6'(DigitSlots - 1)) begin
                     k_ff     <= cnt_ff + 6'd1;
                     state_ff <= neg_ff ? B_SIGN : B_EMIT;
                  end
               end else begin
                  rem_ff <= rem_in;
               end
            end
            B_SIGN: begin
               valid_ff <= 1'b1;
               sym_ff   <= SymMinus;
               final_ff <= 1'b0;
               state_ff <= B_EMIT;
            end
            B_EMIT: begin
               valid_ff <= 1'b1;
               sym_ff   <= alphabet[store_ff[5'(k_ff - 6'd1)]];
               final_ff <= (k_ff == 6'd1);
               k_ff     <= k_ff - 6'd1;
               if (k_ff == 6'd1) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/signed_radix_text_formatter.sv -----
// channel  ports                                          direction
// request  start, busy, req_number_value                  in (busy out)
// response rsp_valid, rsp_text_symbol, rsp_final_symbol   out
// csr      csr_we, csr_index, csr_wdata                   in
//
// front is busy after a start with radix 2..32: check, then queue (2 deep)
// back pops a job and divides, 8 quotient bits a cycle, for each digit, then
// puts out one symbol per cycle; it pops the next job only when idle
// reset is synchronous and restores alphabet "0123456789", radix 10
// busy stays high after the check while the queue is full
// responses are one-cycle strobes; the receiver cannot stall them
module signed_radix_text_formatter
   import srtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_number_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_text_symbol,
   output logic        rsp_final_symbol,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0]  alpha_ff [4];
   logic [5:0]   radix_len_ff;
   alphabet_type alphabet;
   logic         push, full, pop, empty;
   job_type      push_job, pop_job;

   assign alphabet = {alpha_ff[3], alpha_ff[2], alpha_ff[1], alpha_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff[0]  <= 64'd3978425819141910832;
         alpha_ff[1]  <= 64'd14648;
         alpha_ff[2]  <= 64'd0;
         alpha_ff[3]  <= 64'd0;
         radix_len_ff <= 6'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            RegAlphaLo:    alpha_ff[0]  <= csr_wdata;
            RegAlphaMidLo: alpha_ff[1]  <= csr_wdata;
            RegAlphaMidHi: alpha_ff[2]  <= csr_wdata;
            RegAlphaHi:    alpha_ff[3]  <= csr_wdata;
            RegRadixLen:   radix_len_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   srtf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .number_value (req_number_value),
      .busy         (busy),
      .alphabet     (alphabet),
      .radix_len    (radix_len_ff),
      .push         (push),
      .push_job     (push_job),
      .full         (full)
   );

   srtf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   srtf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .alphabet         (alphabet),
      .empty            (empty),
      .pop_job          (pop_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_text_symbol  (rsp_text_symbol),
      .rsp_final_symbol (rsp_final_symbol)
   );

endmodule

// ----- hw/rtl/srtf_checker.sv -----
module srtf_checker
   import srtf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_text_symbol,
   input logic       rsp_final_symbol
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe after reset");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_symbol == SymMinus) |-> !rsp_final_symbol)
      else $error("minus sign flagged as last symbol");

   a_no_plus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_symbol != SymPlus))
      else $error("plus symbol emitted");

endmodule

bind signed_radix_text_formatter srtf_checker u_srtf_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_text_symbol  (rsp_text_symbol),
   .rsp_final_symbol (rsp_final_symbol)
);
